// ----- src/lhbp_pkg.sv -----
// shared types and constants for the local history branch predictor
// no dependencies
package lhbp_pkg;

  localparam int ADDR_W   = 20;
  localparam int ENTRIES  = 256;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int TAG_W    = ADDR_W - SLOT_W;
  localparam int PATTERNS = 16;
  localparam int HIST_W   = $clog2(PATTERNS);
  localparam int CTR_W    = 2;

  localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  typedef struct packed {
    logic [TAG_W-1:0]                 tag;
    logic [HIST_W-1:0]                hist;
    logic [PATTERNS-1:0][CTR_W-1:0]   ctrs;
  } row_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    row_t              row;
  } wr_req_t;

endpackage

// ----- src/lhbp_table.sv -----
// entry table: one row per slot (tag, history, pattern counters) plus valid bits
// depends on lhbp_pkg
module lhbp_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [lhbp_pkg::SLOT_W-1:0] rd_slot,
  input  lhbp_pkg::wr_req_t      wr,
  output lhbp_pkg::row_t         rd_row,
  output logic                   rd_valid
);
  import lhbp_pkg::*;

  row_t               mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  row_t               rd_row_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= wr.row;
    end
  end

  // bypass a row written at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.slot == rd_slot)) begin
        rd_row_r   <= wr.row;
        rd_valid_r <= 1'b1;
      end else begin
        rd_row_r   <= mem[rd_slot];
        rd_valid_r <= valid_r[rd_slot];
      end
    end
  end

  assign rd_row   = rd_row_r;
  assign rd_valid = rd_valid_r;

endmodule

// ----- src/lhbp_update.sv -----
// hit check, prediction and counter/history update for one row
// depends on lhbp_pkg
module lhbp_update (
  input  lhbp_pkg::row_t              row,
  input  logic                        row_valid,
  input  lhbp_pkg::op_t               op,
  input  logic                        taken,
  input  logic [lhbp_pkg::TAG_W-1:0]  tag,
  output logic                        predict_taken,
  output logic                        entry_allocated,
  output lhbp_pkg::row_t              row_nxt
);
  import lhbp_pkg::*;

  row_t             cur;
  logic [CTR_W-1:0] ctr;
  logic [CTR_W-1:0] ctr_nxt;
  logic             miss;

  always_comb begin
    miss = !row_valid || (row.tag != tag);
    cur  = row;
    if (miss) begin
      cur.tag  = tag;
      cur.hist = '0;
      cur.ctrs = '0;
    end
    ctr = cur.ctrs[cur.hist];

    ctr_nxt = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) ctr_nxt = ctr + CTR_W'(1);
    end else begin
      if (ctr != '0) ctr_nxt = ctr - CTR_W'(1);
    end

    row_nxt = cur;
    case (op)
      OP_UPDATE: begin
        row_nxt.ctrs[cur.hist] = ctr_nxt;
        row_nxt.hist           = {cur.hist[HIST_W-2:0], taken};
      end
      default: begin
      end
    endcase

    predict_taken   = ctr[CTR_W-1];
    entry_allocated = miss;
  end

endmodule

// ----- src/local_history_branch_predictor.sv -----
// top level of the two-level local history branch predictor
// depends on lhbp_pkg, lhbp_table, lhbp_update
//
//   port group | direction | contents
//   in_        | in        | operation, branch_address, taken
//   out_       | out       | predict_taken, entry_allocated
//
// one beat per cycle while nothing stalls: table read at accept,
// row update and write-back when the update stage fires.
// a read of a slot written at the same edge uses a table bypass.
// reset clears the valid bits at once, so no clearing pass is needed.
// a stalled output holds the update stage, which then stalls the input.
module local_history_branch_predictor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [lhbp_pkg::ADDR_W-1:0]  in_branch_address,
  input  logic                         in_taken,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_predict_taken,
  output logic                         out_entry_allocated
);
  import lhbp_pkg::*;

  logic              s1_v_r;
  op_t               s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_taken_r;
  logic              out_v_r;
  logic              out_pred_r;
  logic              out_alloc_r;

  logic    fire;
  logic    accept;
  wr_req_t wr;
  row_t    rd_row;
  logic    rd_valid;
  row_t    row_nxt;
  logic    pred;
  logic    alloc;

  assign fire     = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !fire;
  assign accept   = in_valid && !in_stall;

  assign wr.en   = fire;
  assign wr.slot = s1_addr_r[SLOT_W-1:0];
  assign wr.row  = row_nxt;

  lhbp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_slot  (in_branch_address[SLOT_W-1:0]),
    .wr       (wr),
    .rd_row   (rd_row),
    .rd_valid (rd_valid)
  );

  lhbp_update u_update (
    .row             (rd_row),
    .row_valid       (rd_valid),
    .op              (s1_op_r),
    .taken           (s1_taken_r),
    .tag             (s1_addr_r[ADDR_W-1:SLOT_W]),
    .predict_taken   (pred),
    .entry_allocated (alloc),
    .row_nxt         (row_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_t'(in_operation);
      s1_addr_r  <= in_branch_address;
      s1_taken_r <= in_taken;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pred_r  <= pred;
      out_alloc_r <= alloc;
    end
  end

  assign out_valid           = out_v_r;
  assign out_predict_taken   = out_pred_r;
  assign out_entry_allocated = out_alloc_r;

endmodule

// ----- tb/local_history_branch_predictor_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for local_history_branch_predictor: a scoreboard class
// tracks history and counter tables per slot and checks every output beat
// depends on lhbp_pkg and local_history_branch_predictor
module local_history_branch_predictor_tb;
  import lhbp_pkg::*;

  localparam int LONG_HOLD    = 80;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_SIZE    = 32;
  localparam int PHASE_ITEMS  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CTR_W-1:0] TAKEN_ABOVE = CTR_W'(1);

  typedef struct packed {
    logic predict_taken;
    logic entry_allocated;
  } lookup_t;

  class bp_scoreboard;
    bit                valid_bits [ENTRIES];
    logic [TAG_W-1:0]  tags       [ENTRIES];
    logic [HIST_W-1:0] histories  [ENTRIES];
    logic [CTR_W-1:0]  counters   [ENTRIES][PATTERNS];
    lookup_t           expected_lookups [$];
    int                mismatches;

    function new();
      foreach (valid_bits[i]) valid_bits[i] = 1'b0;
      mismatches = 0;
    endfunction

    function void note_request(op_t op, logic [ADDR_W-1:0] addr, logic taken);
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tg;
      logic [HIST_W-1:0] h;
      logic [CTR_W-1:0]  c;
      lookup_t           res;
      slot = addr[SLOT_W-1:0];
      tg = addr[ADDR_W-1:SLOT_W];
      res.entry_allocated = 1'b0;
      if (!valid_bits[slot] || tags[slot] != tg) begin
        valid_bits[slot] = 1'b1;
        tags[slot] = tg;
        histories[slot] = '0;
        for (int p = 0; p < PATTERNS; p++) counters[slot][p] = '0;
        res.entry_allocated = 1'b1;
      end
      h = histories[slot];
      c = counters[slot][h];
      res.predict_taken = (c > TAKEN_ABOVE);
      if (op == OP_UPDATE) begin
        if (taken && c != CTR_MAX) c = c + CTR_W'(1);
        else if (!taken && c != '0) c = c - CTR_W'(1);
        counters[slot][h] = c;
        histories[slot] = {h[HIST_W-2:0], taken};
      end
      expected_lookups.push_back(res);
    endfunction

    function void check_response(logic pt, logic ea);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat predict_taken=%0b entry_allocated=%0b",
                   $time, pt, ea);
        return;
      end
      want = expected_lookups.pop_front();
      if (pt !== want.predict_taken || ea !== want.entry_allocated) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: predict_taken exp %0b got %0b, entry_allocated exp %0b got %0b",
                   $time, want.predict_taken, pt, want.entry_allocated, ea);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_operation = 1'b0;
  logic [ADDR_W-1:0] in_branch_address = '0;
  logic              in_taken = 1'b0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_predict_taken;
  logic              out_entry_allocated;

  bp_scoreboard      sb = new();
  int                idle_pct = 0;
  int                stall_pct = 0;
  bit                hold_armed = 1'b0;
  bit                hold_taken = 1'b0;
  int                hold_left = 0;
  int                cycle_count = 0;
  int                beats_sent = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  local_history_branch_predictor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_branch_address   (in_branch_address),
    .in_taken            (in_taken),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predict_taken   (out_predict_taken),
    .out_entry_allocated (out_entry_allocated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(op_t'(in_operation), in_branch_address, in_taken);
      if (out_valid && !out_stall)
        sb.check_response(out_predict_taken, out_entry_allocated);
    end
  end

  // receiver: one long hold-off when armed, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(op_t op, logic [ADDR_W-1:0] addr, logic taken);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_branch_address <= addr;
    in_taken <= taken;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_directed();
    send_beat(OP_PREDICT, 20'h00000, 1'b0);
    send_beat(OP_PREDICT, 20'h00000, 1'b1);
    // walk the history up to all ones and saturate that counter
    repeat (8) send_beat(OP_UPDATE, 20'h00000, 1'b1);
    send_beat(OP_PREDICT, 20'h00000, 1'b0);
    send_beat(OP_UPDATE, 20'hFFFFF, 1'b0);
    send_beat(OP_UPDATE, 20'hFFFFF, 1'b0);
    send_beat(OP_PREDICT, 20'hFFFFF, 1'b1);
    // aliasing on slot 0 and slot 255
    send_beat(OP_PREDICT, 20'h00100, 1'b0);
    send_beat(OP_PREDICT, 20'h00000, 1'b0);
    send_beat(OP_UPDATE, 20'h000FF, 1'b1);
    send_beat(OP_PREDICT, 20'hFFFFF, 1'b0);
    send_beat(OP_UPDATE, 20'h55555, 1'b1);
    send_beat(OP_UPDATE, 20'hAAAAA, 1'b0);
  endtask

  task automatic send_burst();
    logic [ADDR_W-1:0] addr;
    int                len;
    int                period;
    op_t               op;
    if ($urandom_range(99) < 80) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
    else addr = ADDR_W'($urandom);
    len = $urandom_range(3, 12);
    period = $urandom_range(1, 5);
    for (int j = 0; j < len; j++) begin
      op = ($urandom_range(99) < 70) ? OP_UPDATE : OP_PREDICT;
      if ($urandom_range(99) < 10) send_beat(op, addr, 1'($urandom));
      else send_beat(op, addr, (j % period) != period - 1);
    end
  endtask

  task automatic run_phase(int idle, int stall, int count);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    target = beats_sent + count;
    while (beats_sent < target) begin
      if ($urandom_range(99) < 15)
        send_beat(op_t'($urandom_range(1)), ADDR_W'($urandom), 1'($urandom));
      else
        send_burst();
    end
  endtask

  initial begin
    // few slots, random tags: frequent revisits with some aliasing
    foreach (addr_pool[i])
      addr_pool[i] = {TAG_W'($urandom), SLOT_W'($urandom_range(15))};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    hold_armed = 1'b1;
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(75, 0, PHASE_ITEMS);
    run_phase(0, 75, PHASE_ITEMS);
    run_phase(6, 6, PHASE_ITEMS);
    in_valid <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_lookups.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
